FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define VMU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vmu check failed");

// checked in every cycle, reset included
`define VMU_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("vmu reset check failed");

`endif

FILE: rtl/vmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vmu_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned PROD_W        = 2 * DATA_W;
   localparam int unsigned SQ_W          = 2 * DATA_W;
   localparam int unsigned SAT_W         = 72;
   localparam int unsigned LANES         = 3;
   localparam int unsigned SQ_STAGES     = 32;
   localparam int unsigned THR_W         = 31;
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;

   // pipeline stage numbers
   localparam int unsigned ST_IN   = 1;
   localparam int unsigned ST_MUL  = 2;
   localparam int unsigned ST_SQ   = 3;
   localparam int unsigned ST_PB   = 4;
   localparam int unsigned ST_PROJ = 5;
   localparam int unsigned ST_LEN  = ST_SQ + SQ_STAGES;

   localparam logic [THR_W-1:0] THR_RESET   = 31'd1;
   localparam logic [0:0]       CSR_IDX_THR = 1'b0;

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-DATA_W){1'b0}}, S32_MAX};
   localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-DATA_W+1){1'b1}}, 31'd0};

   typedef logic [3:0] func_type;

   localparam func_type FN_ADD   = 4'd0;
   localparam func_type FN_SUB   = 4'd1;
   localparam func_type FN_SCALE = 4'd2;
   localparam func_type FN_DIV   = 4'd3;
   localparam func_type FN_DOT   = 4'd4;
   localparam func_type FN_LEN   = 4'd5;
   localparam func_type FN_NORM  = 4'd6;
   localparam func_type FN_PROJ  = 4'd7;
   localparam func_type FN_REFL  = 4'd8;
   localparam func_type FN_CROSS = 4'd9;
   localparam func_type FN_INV   = 4'd10;

   typedef struct packed {
      func_type fn_mix;
      func_type fn_proj;
      func_type fn_div;
      func_type fn_out;
      logic     zero_out;
   } lane_ctl_type;

   typedef struct packed {
      logic [DATA_W-1:0] a_mag;
      logic              a_neg;
      logic [DATA_W-1:0] s_mag;
      logic              s_neg;
   } div_prep_type;

   typedef struct packed {
      logic dz;
      logic zr;
   } flag_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      if (v > SAT_HI) begin
         return S32_MAX;
      end else if (v < SAT_LO) begin
         return S32_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/vmu_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vmu_req_if import vmu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   func_type                 func;
   logic signed [DATA_W-1:0] a_x;
   logic signed [DATA_W-1:0] a_y;
   logic signed [DATA_W-1:0] a_z;
   logic signed [DATA_W-1:0] b_x;
   logic signed [DATA_W-1:0] b_y;
   logic signed [DATA_W-1:0] b_z;
   logic signed [DATA_W-1:0] scalar_in;

   modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                   input ready);
   modport sink (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                 output ready);
endinterface

interface vmu_rsp_if import vmu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] r_x;
   logic signed [DATA_W-1:0] r_y;
   logic signed [DATA_W-1:0] r_z;
   logic signed [DATA_W-1:0] r_scalar;
   logic                     div_zero;

   modport source (output valid, r_x, r_y, r_z, r_scalar, div_zero, input ready);
   modport sink (input valid, r_x, r_y, r_z, r_scalar, div_zero, output ready);
endinterface

`default_nettype wire

FILE: rtl/vmu_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module vmu_sqrt import vmu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [SQ_W-1:0]   sq_in,
   output logic      [DATA_W-1:0] len_out
);

   logic [SQ_W-1:0] n_ff [SQ_STAGES];
   logic [SQ_W-1:0] r_ff [SQ_STAGES];
   logic [SQ_W-1:0] n_in [SQ_STAGES];
   logic [SQ_W-1:0] r_in [SQ_STAGES];

   function automatic logic [SQ_W-1:0] stage_bit(input int k);
      return SQ_W'(1) << (SQ_W - 2 - 2 * k);
   endfunction

   function automatic logic [2*SQ_W-1:0] sqrt_step(input logic [SQ_W-1:0] n,
                                                   input logic [SQ_W-1:0] r,
                                                   input logic [SQ_W-1:0] b);
      logic [SQ_W:0] trial;
      trial = {1'b0, r} + {1'b0, b};
      if ({1'b0, n} >= trial) begin
         return {n - trial[SQ_W-1:0], (r >> 1) + b};
      end
      return {n, r >> 1};
   endfunction

   always_comb begin
      {n_in[0], r_in[0]} = sqrt_step(sq_in, '0, stage_bit(0));
      for (int k = 1; k < SQ_STAGES; k++) begin
         {n_in[k], r_in[k]} = sqrt_step(n_ff[k-1], r_ff[k-1], stage_bit(k));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQ_STAGES; k++) begin
            n_ff[k] <= n_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign len_out = r_ff[SQ_STAGES-1][DATA_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/vmu_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module vmu_lane import vmu_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     adv,
   input  wire lane_ctl_type             ctl,
   input  wire logic signed [DATA_W-1:0] a_in,
   input  wire logic signed [DATA_W-1:0] b_in,
   input  wire logic signed [DATA_W-1:0] s_in,
   input  wire logic signed [DATA_W-1:0] x1_a,
   input  wire logic signed [DATA_W-1:0] x1_b,
   input  wire logic signed [DATA_W-1:0] x2_a,
   input  wire logic signed [DATA_W-1:0] x2_b,
   input  wire logic signed [DATA_W-1:0] dot_in,
   input  wire logic        [DATA_W-1:0] len_in,
   output logic signed      [PROD_W-1:0] prod_dot,
   output logic             [PROD_W-1:0] prod_sq,
   output logic signed      [DATA_W-1:0] r_out
);

   localparam int unsigned DW   = DATA_W + FRAC_BITS;
   localparam int unsigned LAST = ST_LEN + DW;
   localparam int unsigned ED   = LAST - ST_PROJ;
   localparam int unsigned PD   = ST_LEN - ST_MUL;

   logic signed [PROD_W-1:0] mdot_ff, mscl_ff, msq_ff, mx1_ff, mx2_ff, mpb_ff;
   logic signed [DATA_W-1:0] a2_ff, b2_ff, a3_ff, b3_ff, a4_ff;
   logic signed [DATA_W-1:0] early3_ff, early4_ff;
   logic signed [DATA_W-1:0] early3_in, early5_in, proj_sat, qsat;
   logic signed [DATA_W-1:0] early_ff [0:ED];
   div_prep_type             prep_in;
   div_prep_type             prep_ff [0:PD];
   div_prep_type             pr;

   logic [DW-1:0]     dvd0;
   logic [DATA_W-1:0] dvs0;
   logic              neg0;
   logic [DATA_W-1:0] rem_ff [DW];
   logic [DATA_W-1:0] rem_in [DW];
   logic [DATA_W-1:0] dvs_ff [DW];
   logic [DW-1:0]     dq_ff  [DW];
   logic [DW-1:0]     dq_in  [DW];
   logic              neg_ff [DW];
   logic [DW-1:0]     qmag;

   function automatic logic [DATA_W+DW-1:0] div_step(input logic [DATA_W-1:0] rem,
                                                     input logic [DW-1:0]     dq,
                                                     input logic [DATA_W-1:0] dvs);
      logic [DATA_W:0] trial;
      trial = {rem, dq[DW-1]};
      if (trial >= {1'b0, dvs}) begin
         return {DATA_W'(trial - {1'b0, dvs}), dq[DW-2:0], 1'b1};
      end
      return {trial[DATA_W-1:0], dq[DW-2:0], 1'b0};
   endfunction

   // operand magnitudes and signs for the divider
   always_comb begin
      prep_in.a_neg = a_in[DATA_W-1];
      prep_in.a_mag = a_in[DATA_W-1] ? unsigned'(-a_in) : unsigned'(a_in);
      prep_in.s_neg = s_in[DATA_W-1];
      prep_in.s_mag = s_in[DATA_W-1] ? unsigned'(-s_in) : unsigned'(s_in);
   end

   always_comb begin
      unique case (ctl.fn_mix)
         FN_ADD:   early3_in = sat32(SAT_W'(a2_ff) + SAT_W'(b2_ff));
         FN_SUB:   early3_in = sat32(SAT_W'(a2_ff) - SAT_W'(b2_ff));
         FN_SCALE: early3_in = sat32(SAT_W'(mscl_ff >>> FRAC_BITS));
         FN_CROSS: early3_in = sat32((SAT_W'(mx1_ff) - SAT_W'(mx2_ff)) >>> FRAC_BITS);
         default:  early3_in = '0;
      endcase
   end

   assign proj_sat = sat32(SAT_W'(mpb_ff >>> FRAC_BITS));

   always_comb begin
      unique case (ctl.fn_proj)
         FN_PROJ: early5_in = proj_sat;
         FN_REFL: early5_in = sat32(SAT_W'(a4_ff) - (SAT_W'(proj_sat) <<< 1));
         default: early5_in = early4_ff;
      endcase
   end

   assign pr = prep_ff[PD];

   always_comb begin
      unique case (ctl.fn_div)
         FN_DIV: begin
            dvd0 = DW'(pr.a_mag) << FRAC_BITS;
            dvs0 = pr.s_mag;
            neg0 = pr.a_neg ^ pr.s_neg;
         end
         FN_NORM: begin
            dvd0 = DW'(pr.a_mag) << FRAC_BITS;
            dvs0 = len_in;
            neg0 = pr.a_neg;
         end
         FN_INV: begin
            dvd0 = DW'(1) << (2 * FRAC_BITS);
            dvs0 = pr.a_mag;
            neg0 = pr.a_neg;
         end
         default: begin
            dvd0 = '0;
            dvs0 = '0;
            neg0 = 1'b0;
         end
      endcase
   end

   always_comb begin
      {rem_in[0], dq_in[0]} = div_step('0, dvd0, dvs0);
      for (int j = 1; j < DW; j++) begin
         {rem_in[j], dq_in[j]} = div_step(rem_ff[j-1], dq_ff[j-1], dvs_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mdot_ff <= PROD_W'(a_in) * PROD_W'(b_in);
         mscl_ff <= PROD_W'(a_in) * PROD_W'(s_in);
         msq_ff  <= PROD_W'(a_in) * PROD_W'(a_in);
         mx1_ff  <= PROD_W'(x1_a) * PROD_W'(x1_b);
         mx2_ff  <= PROD_W'(x2_a) * PROD_W'(x2_b);
         a2_ff   <= a_in;
         b2_ff   <= b_in;

         early3_ff <= early3_in;
         a3_ff     <= a2_ff;
         b3_ff     <= b2_ff;

         mpb_ff    <= PROD_W'(b3_ff) * PROD_W'(dot_in);
         early4_ff <= early3_ff;
         a4_ff     <= a3_ff;

         early_ff[0] <= early5_in;
         for (int k = 1; k <= ED; k++) begin
            early_ff[k] <= early_ff[k-1];
         end

         prep_ff[0] <= prep_in;
         for (int k = 1; k <= PD; k++) begin
            prep_ff[k] <= prep_ff[k-1];
         end

         rem_ff[0] <= rem_in[0];
         dq_ff[0]  <= dq_in[0];
         dvs_ff[0] <= dvs0;
         neg_ff[0] <= neg0;
         for (int j = 1; j < DW; j++) begin
            rem_ff[j] <= rem_in[j];
            dq_ff[j]  <= dq_in[j];
            dvs_ff[j] <= dvs_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign qmag = dq_ff[DW-1];

   always_comb begin
      if (neg_ff[DW-1]) begin
         qsat = (qmag > DW'(S32_MIN)) ? S32_MIN : -signed'(qmag[DATA_W-1:0]);
      end else begin
         qsat = (qmag > DW'(S32_MAX)) ? S32_MAX : signed'(qmag[DATA_W-1:0]);
      end
   end

   always_comb begin
      case (ctl.fn_out) inside
         FN_DIV, FN_INV: r_out = qsat;
         FN_NORM:        r_out = ctl.zero_out ? '0 : qsat;
         default:        r_out = early_ff[ED];
      endcase
   end

   assign prod_dot = mdot_ff;
   assign prod_sq  = unsigned'(msq_ff);

endmodule

`default_nettype wire

FILE: rtl/vector3_math_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// 3D vector unit in signed fixed point with FRAC_BITS fraction bits (Q16.16
// by default). It takes one word per cycle while req.ready is high and
// returns one result word per input word, in order. Each word goes through
// the multiply stages of three lanes, one per component, then one 32-stage
// square root pipeline shared by the lanes, then a (32 + FRAC_BITS) stage
// restoring divider in each lane, then the output register. The pipeline
// only holds when its last stage has a result and the output register is
// still full. near_zero_threshold sits at byte address 0 and resets to 1.
module vector3_math_unit import vmu_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   vmu_req_if.sink                    req,
   vmu_rsp_if.source                  rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int unsigned DW   = DATA_W + FRAC_BITS;
   localparam int unsigned LAST = ST_LEN + DW;

   logic [THR_W-1:0] thr_ff;
   logic             adv;

   logic     v_ff  [ST_IN:LAST];
   func_type fn_ff [ST_IN:LAST];
   flag_type fl_ff [ST_SQ:LAST];
   logic signed [DATA_W-1:0] rs_ff [ST_SQ:LAST];

   logic signed [DATA_W-1:0] a1_ff [LANES];
   logic signed [DATA_W-1:0] b1_ff [LANES];
   logic signed [DATA_W-1:0] s1_ff;
   logic                     sz2_ff, az2_ff;

   logic signed [PROD_W-1:0] prod_dot [LANES];
   logic        [PROD_W-1:0] prod_sq  [LANES];
   logic signed [DATA_W-1:0] r_lane   [LANES];

   logic signed [SAT_W-1:0]  dsum;
   logic signed [DATA_W-1:0] dot_in;
   logic signed [DATA_W-1:0] dot3_ff;
   logic [SQ_W-1:0]          sq_in, sq3_ff;
   logic                     nz;
   flag_type                 fl3_in;
   logic [DATA_W-1:0]        len_w;
   logic signed [DATA_W-1:0] rs_len;
   lane_ctl_type             lctl;
   logic                     dz_op_last;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rx_ff, ry_ff, rz_ff, rs_out_ff;
   logic                     dz_ff;

   // config port
   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_THR) ? CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (psel && penable && pwrite && paddr[CSR_ADDR_W-1] == CSR_IDX_THR) begin
         thr_ff <= pwdata[THR_W-1:0];
      end
   end

   // flow control
   assign adv       = !(v_ff[LAST] && rsp_valid_ff && !rsp.ready);
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = ST_IN; k <= LAST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[ST_IN] <= req.valid;
         for (int k = ST_IN + 1; k <= LAST; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // word capture and control line
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff[0] <= req.a_x;
         a1_ff[1] <= req.a_y;
         a1_ff[2] <= req.a_z;
         b1_ff[0] <= req.b_x;
         b1_ff[1] <= req.b_y;
         b1_ff[2] <= req.b_z;
         s1_ff    <= req.scalar_in;
         fn_ff[ST_IN] <= req.func;
         for (int k = ST_IN + 1; k <= LAST; k++) begin
            fn_ff[k] <= fn_ff[k-1];
         end
         sz2_ff <= (s1_ff == '0);
         az2_ff <= (a1_ff[0] == '0) || (a1_ff[1] == '0) || (a1_ff[2] == '0);
      end
   end

   // lanes
   always_comb begin
      lctl.fn_mix   = fn_ff[ST_MUL];
      lctl.fn_proj  = fn_ff[ST_PB];
      lctl.fn_div   = fn_ff[ST_LEN];
      lctl.fn_out   = fn_ff[LAST];
      lctl.zero_out = fl_ff[LAST].zr;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int J = (i + 1) % LANES;
      localparam int K = (i + 2) % LANES;
      vmu_lane #(
         .FRAC_BITS(FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .adv     (adv),
         .ctl     (lctl),
         .a_in    (a1_ff[i]),
         .b_in    (b1_ff[i]),
         .s_in    (s1_ff),
         .x1_a    (a1_ff[J]),
         .x1_b    (b1_ff[K]),
         .x2_a    (a1_ff[K]),
         .x2_b    (b1_ff[J]),
         .dot_in  (dot3_ff),
         .len_in  (len_w),
         .prod_dot(prod_dot[i]),
         .prod_sq (prod_sq[i]),
         .r_out   (r_lane[i])
      );
   end

   // merge of lane products
   always_comb begin
      dsum   = SAT_W'(prod_dot[0]) + SAT_W'(prod_dot[1]) + SAT_W'(prod_dot[2]);
      dot_in = sat32(dsum >>> FRAC_BITS);
      sq_in  = prod_sq[0] + prod_sq[1] + prod_sq[2];
      nz     = (sq_in >> FRAC_BITS) >= SQ_W'(thr_ff);
      fl3_in.dz = (fn_ff[ST_MUL] == FN_DIV && sz2_ff)
                || (fn_ff[ST_MUL] == FN_INV && az2_ff)
                || (fn_ff[ST_MUL] == FN_NORM && nz && sq_in == '0);
      fl3_in.zr = !(nz && sq_in != '0);
   end

   vmu_sqrt u_sqrt (
      .clock  (clock),
      .adv    (adv),
      .sq_in  (sq3_ff),
      .len_out(len_w)
   );

   always_comb begin
      if (fn_ff[ST_LEN] == FN_LEN) begin
         rs_len = len_w[DATA_W-1] ? S32_MAX : signed'(len_w);
      end else begin
         rs_len = rs_ff[ST_LEN];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot3_ff      <= dot_in;
         sq3_ff       <= sq_in;
         fl_ff[ST_SQ] <= fl3_in;
         rs_ff[ST_SQ] <= (fn_ff[ST_MUL] == FN_DOT) ? dot_in : '0;
         for (int k = ST_SQ + 1; k <= LAST; k++) begin
            fl_ff[k] <= fl_ff[k-1];
            rs_ff[k] <= (k == ST_LEN + 1) ? rs_len : rs_ff[k-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[LAST] || (rsp_valid_ff && !rsp.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_ff[LAST]) begin
         rx_ff     <= r_lane[0];
         ry_ff     <= r_lane[1];
         rz_ff     <= r_lane[2];
         rs_out_ff <= rs_ff[LAST];
         dz_ff     <= fl_ff[LAST].dz;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.r_x      = rx_ff;
   assign rsp.r_y      = ry_ff;
   assign rsp.r_z      = rz_ff;
   assign rsp.r_scalar = rs_out_ff;
   assign rsp.div_zero = dz_ff;

   assign dz_op_last = (fn_ff[LAST] == FN_DIV) || (fn_ff[LAST] == FN_INV)
                     || (fn_ff[LAST] == FN_NORM);

   `VMU_ASSERT(a_stall_keeps_last, (v_ff[LAST] && rsp_valid_ff && !rsp.ready) |=> v_ff[LAST])
   `VMU_ASSERT(a_last_loads_out, (adv && v_ff[LAST]) |=> rsp_valid_ff)
   `VMU_ASSERT(a_dz_ops, (v_ff[LAST] && fl_ff[LAST].dz) |-> dz_op_last)
   `VMU_ASSERT_RST(a_thr_reset, reset |=> (thr_ff == THR_RESET))

endmodule

`default_nettype wire
